>>> hw/rtl/krt_pkg.sv
package krt_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_BITS    = 64;
  localparam int FIRST_BITS  = 64;
  localparam int SECOND_BITS = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = 7;

  localparam int IN_W   = 2 + 3 * 64;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = 1 + 64 + 64 + CNT_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [FIRST_BITS-1:0]  first;
    logic [SECOND_BITS-1:0] second;
  } record_t;

  // Per-cell command for the current cycle.
  typedef struct packed {
    logic compare;   // latch the key match
    logic load_new;  // take the request record (append at the tail)
    logic shift;     // take the upper neighbor's record (compaction)
    logic modify;    // overwrite the values if this cell matched
  } cell_ctl_t;

endpackage

>>> hw/rtl/krt_cell.sv
module krt_cell (
  input  logic              clk,
  input  logic              rst,
  input  krt_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  krt_pkg::record_t  req,
  input  krt_pkg::record_t  upper,
  output krt_pkg::record_t  rec,
  output logic              hit
);
  import krt_pkg::*;

  // Match flag: control state, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.compare) begin
      hit <= valid && (rec.key == req.key);
    end
  end

  // Record payload: no reset; the user must write it only when it becomes valid, the cell does not enforce it.
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      rec <= req;
    end else if (ctl.shift) begin
      rec <= upper;
    end else if (ctl.modify && hit) begin
      // keep the key, take both new values
      rec <= {rec.key, req.first, req.second};
    end
  end

endmodule

>>> hw/rtl/keyed_record_table.sv
// keyed_record_table: a compact key/value table of CAPACITY records held in a
// row of cells. Valid records always sit in cells 0 .. entry_count-1.
//
// Input channel (s_axis): one request item carries req_type, key and two value
// words. Add appends at the tail if the key is absent and the table has room;
// delete removes the match and every higher cell takes its upper neighbor's
// record in the same cycle; modify rewrites both values of the match; query
// reads them back.
// Output channel (m_axis): exactly one result item per request, with a success
// flag, the query values (zero otherwise) and the entry count after the request.
//
// Timing: an item is accepted, all cells compare its key in the next cycle,
// and the update plus result register load happen in the apply state after
// the compare, once the result register is free or being drained. One item is
// in work at a time: no new item is taken until the compare-then-apply
// sequence over the cell row is through.
// A stalled receiver holds the result register; the block still takes the
// next item and holds it before the update until the result is taken.
// Reset empties the table (count to zero) and drops any item in flight.
module keyed_record_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // req_type[1:0], key[65:2], first_value[129:66], second_value[193:130], zero pad
  input  logic [krt_pkg::IN_TW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // success[0], first_out[64:1], second_out[128:65], entry_count[135:129]
  output logic [krt_pkg::OUT_TW-1:0]  m_axis_tdata
);
  import krt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]       state, state_next;
  logic [1:0]       req_op;
  record_t          req;
  logic [CNT_W-1:0] count, count_next;

  record_t          cell_rec [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] at_or_after;
  cell_ctl_t        ctl [CAPACITY];

  logic             any_hit;
  logic             full;
  logic             go;
  logic             ok;
  record_t          rd;

  logic             out_valid;
  logic [OUT_TW-1:0] out_data;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign any_hit = |hit;
  assign full    = (count >= CNT_W'(CAPACITY));
  // Apply only when the result register is free or being drained.
  assign go      = (state == ST_APPLY) && (!out_valid || m_axis_tready);

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_op     <= s_axis_tdata[1:0];
      req.key    <= s_axis_tdata[2 +: KEY_BITS];
      req.first  <= s_axis_tdata[66 +: FIRST_BITS];
      req.second <= s_axis_tdata[130 +: SECOND_BITS];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: if (go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Mark the matching cell and everything above it for compaction.
  always_comb begin
    at_or_after[0] = hit[0];
    for (int i = 1; i < CAPACITY; i++) begin
      at_or_after[i] = at_or_after[i-1] | hit[i];
    end
  end

  // Read out the matching record; keys are unique so at most one hit.
  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) rd = rd | cell_rec[i];
    end
  end

  always_comb begin
    ok = 1'b0;
    count_next = count;
    case (req_op)
      OP_ADD: begin
        ok = !any_hit && !full;
        if (ok) count_next = count + 1'b1;
      end
      OP_DELETE: begin
        ok = any_hit;
        if (ok) count_next = count - 1'b1;
      end
      default: ok = any_hit;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].compare  = (state == ST_CMP);
      ctl[i].load_new = go && (req_op == OP_ADD) && !any_hit && !full &&
                        (count[IDX_W-1:0] == IDX_W'(i));
      ctl[i].shift    = go && (req_op == OP_DELETE) && at_or_after[i];
      ctl[i].modify   = go && (req_op == OP_MODIFY);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      record_t upper;
      if (g == CAPACITY - 1) begin : g_top
        assign upper = cell_rec[g];
      end else begin : g_mid
        assign upper = cell_rec[g+1];
      end
      krt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl[g]),
        .valid (count > CNT_W'(g)),
        .req   (req),
        .upper (upper),
        .rec   (cell_rec[g]),
        .hit   (hit[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: query values only on a query hit.
  always_ff @(posedge clk) begin
    if (go) begin
      if (req_op == OP_QUERY && any_hit) begin
        out_data <= {count_next, rd.second, rd.first, ok};
      end else begin
        out_data <= {count_next, {SECOND_BITS{1'b0}}, {FIRST_BITS{1'b0}}, ok};
      end
    end
  end

endmodule
